// File: rtl/icsp_pkg.sv
package icsp_pkg;

  localparam int NUM_STRIPS  = 8;
  localparam int STRIP_SEL_W = 3;
  localparam int ORDER_W     = NUM_STRIPS * STRIP_SEL_W;
  localparam int CFG_DATA_W  = ORDER_W;

  // identity order: entry s holds s
  localparam logic [ORDER_W-1:0] ORDER_RESET = 24'hFAC688;

  typedef enum logic {
    MODE_SCRAMBLE   = 1'b0,
    MODE_UNSCRAMBLE = 1'b1
  } mode_t;

  typedef enum logic {
    REG_MODE  = 1'b0,
    REG_ORDER = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    mode_t              mode;
    logic [ORDER_W-1:0] order;
  } cfg_t;

  // read issued to the line store, aligned with its registered data
  typedef struct packed {
    logic valid;
    logic row_end;
  } rd_tag_t;

  function automatic logic [STRIP_SEL_W-1:0] strip_target(
    input logic [ORDER_W-1:0]     order,
    input logic [STRIP_SEL_W-1:0] s
  );
    logic [STRIP_SEL_W-1:0] t;
    t = '0;
    for (int i = 0; i < NUM_STRIPS; i++) begin
      if (s == STRIP_SEL_W'(i)) begin
        t = order[STRIP_SEL_W*i +: STRIP_SEL_W];
      end
    end
    return t;
  endfunction

endpackage

// File: rtl/icsp_ram.sv
module icsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/icsp_front.sv
module icsp_front
  import icsp_pkg::*;
#(
  parameter int LINE_WIDTH = 512,
  parameter int PIXEL_BITS = 32,
  localparam int AW        = $clog2(2 * LINE_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  logic                  drain,
  input  cfg_t                  cfg,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [PIXEL_BITS-1:0] wr_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  output rd_tag_t               tag
);

  localparam int STRIP       = LINE_WIDTH / NUM_STRIPS;
  localparam int MAPPED_COLS = NUM_STRIPS * STRIP;
  localparam int COL_W       = $clog2(LINE_WIDTH);
  localparam int OFF_W       = $clog2(STRIP);

  logic [COL_W-1:0]       wr_col, wr_col_next, rd_col, rd_col_next;
  logic [OFF_W-1:0]       wr_off, wr_off_next, rd_off, rd_off_next;
  logic [STRIP_SEL_W-1:0] wr_strip, wr_strip_next, rd_strip, rd_strip_next;
  logic                   bank, bank_next;
  logic                   row_ready, row_ready_next;

  logic             wr_last, rd_last, wr_tail, rd_tail;
  logic [COL_W-1:0] wr_map, rd_map;

  assign wr_last = wr_col == COL_W'(LINE_WIDTH - 1);
  assign rd_last = rd_col == COL_W'(LINE_WIDTH - 1);
  // columns past the last full strip pass straight through
  assign wr_tail = {1'b0, wr_col} >= (COL_W+1)'(MAPPED_COLS);
  assign rd_tail = {1'b0, rd_col} >= (COL_W+1)'(MAPPED_COLS);

  assign wr_map = (cfg.mode == MODE_UNSCRAMBLE && !wr_tail)
                ? COL_W'(STRIP * int'(strip_target(cfg.order, wr_strip)) + int'(wr_off))
                : wr_col;
  assign rd_map = (cfg.mode == MODE_SCRAMBLE && !rd_tail)
                ? COL_W'(STRIP * int'(strip_target(cfg.order, rd_strip)) + int'(rd_off))
                : rd_col;

  assign rd_en   = accept && row_ready;
  assign rd_addr = bank ? AW'(rd_map) : AW'(rd_map) + AW'(LINE_WIDTH);
  assign wr_en   = accept && !drain;
  assign wr_addr = bank ? AW'(wr_map) + AW'(LINE_WIDTH) : AW'(wr_map);
  assign wr_data = pixel;

  always_comb begin
    wr_col_next    = wr_col;
    wr_off_next    = wr_off;
    wr_strip_next  = wr_strip;
    rd_col_next    = rd_col;
    rd_off_next    = rd_off;
    rd_strip_next  = rd_strip;
    bank_next      = bank;
    row_ready_next = row_ready;

    if (rd_en) begin
      if (rd_last) begin
        rd_col_next    = '0;
        rd_off_next    = '0;
        rd_strip_next  = '0;
        row_ready_next = 1'b0;
      end else begin
        rd_col_next = rd_col + 1'b1;
        if (rd_off == OFF_W'(STRIP - 1)) begin
          rd_off_next   = '0;
          rd_strip_next = rd_strip + 1'b1;
        end else begin
          rd_off_next = rd_off + 1'b1;
        end
      end
    end

    if (wr_en) begin
      if (wr_last) begin
        wr_col_next    = '0;
        wr_off_next    = '0;
        wr_strip_next  = '0;
        bank_next      = ~bank;
        row_ready_next = 1'b1;
        rd_col_next    = '0;
        rd_off_next    = '0;
        rd_strip_next  = '0;
      end else begin
        wr_col_next = wr_col + 1'b1;
        if (wr_off == OFF_W'(STRIP - 1)) begin
          wr_off_next   = '0;
          wr_strip_next = wr_strip + 1'b1;
        end else begin
          wr_off_next = wr_off + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_col    <= '0;
      wr_off    <= '0;
      wr_strip  <= '0;
      rd_col    <= '0;
      rd_off    <= '0;
      rd_strip  <= '0;
      bank      <= 1'b0;
      row_ready <= 1'b0;
      tag       <= '0;
    end else begin
      wr_col    <= wr_col_next;
      wr_off    <= wr_off_next;
      wr_strip  <= wr_strip_next;
      rd_col    <= rd_col_next;
      rd_off    <= rd_off_next;
      rd_strip  <= rd_strip_next;
      bank      <= bank_next;
      row_ready <= row_ready_next;
      tag       <= '{valid: rd_en, row_end: rd_last};
    end
  end

endmodule

// File: rtl/icsp_back.sv
module icsp_back
  import icsp_pkg::*;
#(
  parameter int PIXEL_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rd_tag_t               tag,
  input  logic [PIXEL_BITS-1:0] rd_data,
  output logic                  full,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [PIXEL_BITS-1:0] out_pixel,
  output logic                  row_end
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 2);

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  row_end;
  } entry_t;

  entry_t           buf_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, occupancy;
  logic             push, pop;

  assign push = tag.valid;
  assign pop  = result_valid && !result_stall;

  // reads already in flight hold a slot
  assign occupancy = count + CNT_W'(tag.valid);
  assign full      = occupancy >= CNT_W'(DEPTH);

  assign result_valid = count != '0;
  assign out_pixel    = buf_q[rd_ptr].pixel;
  assign row_end      = buf_q[rd_ptr].row_end;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= '{pixel: rd_data, row_end: tag.row_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// File: rtl/image_column_strip_permuter_top.sv
// a result is offered once its line store read data is registered and then written into the result queue
// throughput: one pixel transaction per cycle while pixel_stall is low; each may write and read the line store
// input stalls only when the four-entry result queue and the read in flight fill it
// reset (rst, synchronous): counters, bank, row flag and queue cleared, scramble identity order
// the line store itself is not cleared; it is written before it is read
module image_column_strip_permuter_top
  import icsp_pkg::*;
#(
  parameter int LINE_WIDTH = 512,
  parameter int PIXEL_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // pixel channel
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  logic                  drain,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [PIXEL_BITS-1:0] out_pixel,
  output logic                  row_end,
  // register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(2 * LINE_WIDTH);

  cfg_t                  cfg;
  logic                  accept;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [PIXEL_BITS-1:0] wr_data, rd_data;
  rd_tag_t               tag;
  logic                  full;

  // registers are always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= MODE_SCRAMBLE;
      cfg.order <= ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:  cfg.mode  <= mode_t'(cfg_data[0]);
        REG_ORDER: cfg.order <= cfg_data[ORDER_W-1:0];
        default:   ;
      endcase
    end
  end

  // stall comes from registered queue state only
  assign pixel_stall = full;
  assign accept      = pixel_valid && !pixel_stall;

  // front end: column counters, strip mapping, bank control, store access
  icsp_front #(
    .LINE_WIDTH (LINE_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .pixel   (pixel),
    .drain   (drain),
    .cfg     (cfg),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .tag     (tag)
  );

  // double line store: bank in the upper half of the address range
  icsp_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (2 * LINE_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // back end: result queue decoupling the output stall from the store
  icsp_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .tag          (tag),
    .rd_data      (rd_data),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_pixel    (out_pixel),
    .row_end      (row_end)
  );

endmodule
